// File: rtl/dhcp_pkg.sv
// Shared types and constants for the DHCP reply parser and lease stage machine.
`default_nettype none
package dhcp_pkg;
    localparam logic [7:0] OPT_PAD = 8'd0;
    localparam logic [7:0] OPT_MASK = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS = 8'd6;
    localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END = 8'd255;
    localparam logic [15:0] SERVER_PORT = 16'd67;
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK = 8'd5;
    localparam logic [7:0] MSG_NAK = 8'd6;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK = 2'd2;
    localparam logic [1:0] KIND_NAK = 2'd3;

    localparam logic [1:0] STAGE_DISC = 2'd0;
    localparam logic [1:0] STAGE_REQ = 2'd1;
    localparam logic [1:0] STAGE_LEASED = 2'd2;

    localparam logic [0:0] CFG_MAC = 1'b0;
    localparam logic [0:0] CFG_SEED = 1'b1;

    // classified datagram passed from parser to stage machine
    typedef struct packed {
        logic        status_only;
        logic [1:0]  kind;
        logic [31:0] ip;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
        logic [31:0] server;
    } t_event;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  kind;
        logic [1:0]  stage;
        logic        send_owed;
        logic [31:0] ip;
        logic [31:0] mask;
        logic [31:0] router;
        logic [31:0] dns;
        logic [31:0] server;
    } t_result;
endpackage
`default_nettype wire

// File: rtl/dhcp_reply_parser_lease_fsm.sv
// Top level: DHCP reply parser with lease stage machine.
`default_nettype none
// Takes one payload byte per cycle, back to back while the event output is
// not stalled, starting at the BOOTP op byte. A result appears for every
// last-marked byte and every status-only item; the parser registers the
// classified datagram and a two-entry queue feeds the stage machine, whose
// result register holds until taken. Configuration writes
// (index 0 client MAC, index 1 exchange seed) must be made while idle.
module dhcp_reply_parser_lease_fsm #(
    parameter int MAX_DATAGRAM_BYTES = 2048
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [23:0]  s_axis_tdata,  // data_byte[7:0], source_port[23:8]
    input  wire  [0:0]   s_axis_tuser,  // no_datagram[0]
    input  wire          s_axis_tlast,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [167:0] m_axis_tdata,  // accepted, reply_kind, client_stage, send_owed,
                                        // lease_ip, netmask, router, dns, server, zero pad
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire          i_cfg_index,
    input  wire  [47:0]  i_cfg_data
);
    import dhcp_pkg::*;

    logic [47:0] r_mac;
    logic [15:0] r_seed;
    logic        ev_valid, ev_ready;
    t_event      ev;
    t_result     res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= 48'd0;
            r_seed <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAC: r_mac <= i_cfg_data;
                CFG_SEED: r_seed <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dhcp_parser #(.MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata[7:0]), .i_last(s_axis_tlast),
        .i_port(s_axis_tdata[23:8]), .i_nodgram(s_axis_tuser[0]),
        .i_mac(r_mac), .i_seed(r_seed),
        .o_ev_valid(ev_valid), .i_ev_ready(ev_ready), .o_ev(ev)
    );

    dhcp_lease u_lease (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ev_valid(ev_valid), .o_ev_ready(ev_ready), .i_ev(ev),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {2'b00, res.server, res.dns, res.router, res.mask, res.ip,
                           res.send_owed, res.stage, res.kind, res.accepted};
endmodule
`default_nettype wire

// File: rtl/dhcp_parser.sv
// Front end: byte-wise header checks, option walk, and datagram classification.
`default_nettype none
module dhcp_parser #(
    parameter int MAX_DATAGRAM_BYTES = 2048
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [7:0]            i_byte,
    input  wire                   i_last,
    input  wire  [15:0]           i_port,
    input  wire                   i_nodgram,
    input  wire  [47:0]           i_mac,
    input  wire  [15:0]           i_seed,
    output logic                  o_ev_valid,
    input  wire                   i_ev_ready,
    output dhcp_pkg::t_event      o_ev
);
    import dhcp_pkg::*;

    typedef enum logic [3:0] {
        PH_CODE  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    localparam int PW = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam logic [PW-1:0] MAXP = PW'(MAX_DATAGRAM_BYTES);
    localparam logic [PW-1:0] OPT_START = PW'(240);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_good, n_good;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_code, n_code;
    logic [7:0]    r_rem, n_rem;
    logic [31:0]   r_cap, n_cap;
    logic [2:0]    r_cnt, n_cnt;
    logic [7:0]    r_msg, n_msg;
    logic [31:0]   r_f [5];
    logic [31:0]   n_f [5];

    logic        take;
    logic        want_en;
    logic [7:0]  want;
    logic [7:0]  rem_dec;
    t_event      ev;
    logic        emit;

    assign o_ready = !o_ev_valid || i_ev_ready;
    assign take = i_valid && o_ready;

    always_comb begin
        want_en = 1'b1;
        want = 8'd0;
        case (r_pos)
            PW'(0): want = 8'd2;
            PW'(2): want = 8'd6;
            PW'(4): want = i_seed[15:8];
            PW'(5): want = i_seed[7:0];
            PW'(6): want = i_mac[15:8];
            PW'(7): want = i_mac[7:0];
            PW'(28): want = i_mac[47:40];
            PW'(29): want = i_mac[39:32];
            PW'(30): want = i_mac[31:24];
            PW'(31): want = i_mac[23:16];
            PW'(32): want = i_mac[15:8];
            PW'(33): want = i_mac[7:0];
            PW'(236): want = 8'd99;
            PW'(237): want = 8'd130;
            PW'(238): want = 8'd83;
            PW'(239): want = 8'd99;
            default: want_en = 1'b0;
        endcase
    end

    assign rem_dec = r_rem - 8'd1;

    always_comb begin
        n_pos = r_pos;
        n_good = r_good;
        n_phase = r_phase;
        n_code = r_code;
        n_rem = r_rem;
        n_cap = r_cap;
        n_cnt = r_cnt;
        n_msg = r_msg;
        for (int k = 0; k < 5; k++) n_f[k] = r_f[k];
        if (r_pos < MAXP) begin
            n_pos = r_pos + PW'(1);
            if (r_pos < OPT_START) begin
                if (want_en && want != i_byte) n_good = 1'b0;
                if (r_pos >= PW'(16) && r_pos < PW'(20)) n_f[0] = {r_f[0][23:0], i_byte};
            end else begin
                case (r_phase)
                    PH_CODE: begin
                        if (i_byte == OPT_END) n_phase = PH_DONE;
                        else if (i_byte != OPT_PAD) begin
                            n_code = i_byte;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_rem = i_byte;
                        n_cap = 32'd0;
                        n_cnt = 3'd0;
                        n_phase = (i_byte == 8'd0) ? PH_CODE : PH_VALUE;
                    end
                    PH_VALUE: begin
                        if (r_cnt < 3'd4) begin
                            n_cap = {r_cap[23:0], i_byte};
                            n_cnt = r_cnt + 3'd1;
                        end
                        n_rem = rem_dec;
                        if (rem_dec == 8'd0) begin
                            n_phase = PH_CODE;
                            if (r_code == OPT_MSG_TYPE) begin
                                if (n_cnt == 3'd1) n_msg = n_cap[7:0];
                            end else if (n_cnt == 3'd4) begin
                                if (r_code == OPT_MASK) n_f[1] = n_cap;
                                else if (r_code == OPT_ROUTER) n_f[2] = n_cap;
                                else if (r_code == OPT_DNS) n_f[3] = n_cap;
                                else if (r_code == OPT_SERVER_ID) n_f[4] = n_cap;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        ev.status_only = i_nodgram;
        ev.kind = KIND_NONE;
        if (!i_nodgram && n_good && n_pos >= OPT_START && i_port == SERVER_PORT) begin
            if (n_msg == MSG_OFFER) ev.kind = KIND_OFFER;
            else if (n_msg == MSG_ACK) ev.kind = KIND_ACK;
            else if (n_msg == MSG_NAK) ev.kind = KIND_NAK;
        end
        ev.ip = n_f[0];
        ev.mask = n_f[1];
        ev.router = n_f[2];
        ev.dns = n_f[3];
        ev.server = n_f[4];
    end

    assign emit = take && (i_nodgram || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ev_valid <= 1'b0;
        end else if (o_ready) begin
            o_ev_valid <= emit;
        end
        if (emit) o_ev <= ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && !i_nodgram && i_last)) begin
            r_pos <= '0;
            r_good <= 1'b1;
            r_phase <= PH_CODE;
            r_code <= 8'd0;
            r_rem <= 8'd0;
            r_cap <= 32'd0;
            r_cnt <= 3'd0;
            r_msg <= 8'd0;
            for (int k = 0; k < 5; k++) r_f[k] <= 32'd0;
        end else if (take && !i_nodgram) begin
            r_pos <= n_pos;
            r_good <= n_good;
            r_phase <= n_phase;
            r_code <= n_code;
            r_rem <= n_rem;
            r_cap <= n_cap;
            r_cnt <= n_cnt;
            r_msg <= n_msg;
            for (int k = 0; k < 5; k++) r_f[k] <= n_f[k];
        end
    end
endmodule
`default_nettype wire

// File: rtl/dhcp_lease.sv
// Back end: two-entry queue of classified datagrams and the lease stage machine.
`default_nettype none
module dhcp_lease (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_ev_valid,
    output logic               o_ev_ready,
    input  dhcp_pkg::t_event   i_ev,
    output logic               o_valid,
    input  wire                i_ready,
    output dhcp_pkg::t_result  o_res
);
    import dhcp_pkg::*;

    t_event     r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_stage, n_stage;
    logic [31:0] r_lease [5];
    t_event     hd;
    t_result    res;
    logic       acc;
    logic       push, pop, load_lease;

    assign o_ev_ready = (r_cnt != 2'd2);
    assign push = i_ev_valid && o_ev_ready;
    assign pop = (r_cnt != 2'd0) && (!o_valid || i_ready);
    assign hd = r_q[r_rd];

    always_comb begin
        acc = 1'b0;
        load_lease = 1'b0;
        n_stage = r_stage;
        if (!hd.status_only) begin
            if (hd.kind == KIND_OFFER && r_stage == STAGE_DISC) begin
                acc = 1'b1; load_lease = 1'b1; n_stage = STAGE_REQ;
            end else if (hd.kind == KIND_ACK && r_stage == STAGE_REQ) begin
                acc = 1'b1; load_lease = 1'b1; n_stage = STAGE_LEASED;
            end else if (hd.kind == KIND_NAK) begin
                acc = 1'b1; n_stage = STAGE_DISC;
            end
        end
        res.accepted = acc;
        res.kind = hd.kind;
        res.stage = n_stage;
        res.send_owed = (acc || hd.status_only) && n_stage != STAGE_LEASED;
        res.ip = load_lease ? hd.ip : r_lease[0];
        res.mask = load_lease ? hd.mask : r_lease[1];
        res.router = load_lease ? hd.router : r_lease[2];
        res.dns = load_lease ? hd.dns : r_lease[3];
        res.server = load_lease ? hd.server : r_lease[4];
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_ev;
        if (pop) o_res <= res;
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            o_valid <= 1'b0;
            r_stage <= STAGE_DISC;
            for (int k = 0; k < 5; k++) r_lease[k] <= 32'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            if (pop) begin
                r_stage <= n_stage;
                if (load_lease) begin
                    r_lease[0] <= hd.ip;
                    r_lease[1] <= hd.mask;
                    r_lease[2] <= hd.router;
                    r_lease[3] <= hd.dns;
                    r_lease[4] <= hd.server;
                end
            end
        end
    end
endmodule
`default_nettype wire
